@@ src/sbha_pkg.sv @@
// Shared constants and types for the spectrum bar height averager.
// Used by the front end, the job queue, the back end and the top level.
// No dependencies.
package sbha_pkg;

	// display geometry and per-column bin limit
	localparam int Rows    = 48;
	localparam int Columns = 16;
	localparam int MaxBins = 512;

	// field and datapath widths
	localparam int MagW    = 16;
	localparam int ColW    = 4;
	localparam int HeightW = 8;
	localparam int SumW    = 18;
	localparam int CntW    = $clog2(MaxBins + 1);
	localparam int PctW    = 7;
	localparam int ProdW   = 15;
	localparam int StepW   = $clog2(SumW);

	localparam int FullPercent = 100;
	localparam int MinKept     = 10;

	// x / 100 as (x * 5243) >> 19, exact for x up to 250 * 100
	localparam int RecipMul   = 5243;
	localparam int RecipShift = 19;

	localparam int QueueDepth = 4;
	localparam int PtrW       = $clog2(QueueDepth);

	// one finished column handed from the front end to the back end
	typedef struct packed {
		logic [ColW-1:0] col;
		logic [SumW-1:0] sum;
		logic [CntW-1:0] cnt;
	} col_job_t;

endpackage

@@ src/sbha_front.sv @@
// Front end: scales each bin to a height, filters and accumulates per column.
// Pushes one column job into the queue on the last bin. Depends on sbha_pkg.
module sbha_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     bin_valid,
	output logic                     bin_ready,
	input  logic [sbha_pkg::MagW-1:0] bin_mag,
	input  logic [sbha_pkg::ColW-1:0] bin_col,
	input  logic                     bin_last,
	input  logic                     queue_full,
	output logic                     job_push,
	output sbha_pkg::col_job_t       job
);

	logic [sbha_pkg::MagW+4:0]    scaled;
	logic [sbha_pkg::MagW-4:0]    pct_raw;
	logic [sbha_pkg::PctW-1:0]    pct;
	logic                         in_range;
	logic                         stall;
	logic                         kept;
	logic [31:0]                  recip_prod;
	logic [sbha_pkg::SumW-1:0]    sum_nxt;
	logic [sbha_pkg::CntW-1:0]    cnt_nxt;

	logic                         v_s1, v_s2, v_s3;
	logic                         last_s1, last_s2, last_s3;
	logic [sbha_pkg::ColW-1:0]    col_s1, col_s2, col_s3;
	logic [sbha_pkg::PctW-1:0]    pct_s1;
	logic [sbha_pkg::ProdW-1:0]   prod_s2;
	logic [sbha_pkg::HeightW-1:0] h_s3;
	logic [sbha_pkg::SumW-1:0]    sum_q;
	logic [sbha_pkg::CntW-1:0]    cnt_q;

	// mag * 20 / 256, saturated at full scale
	assign scaled   = ({5'd0, bin_mag} << 4) + ({5'd0, bin_mag} << 2);
	assign pct_raw  = scaled[sbha_pkg::MagW+4:8];
	assign pct      = (pct_raw > sbha_pkg::FullPercent) ? sbha_pkg::PctW'(sbha_pkg::FullPercent)
		: pct_raw[sbha_pkg::PctW-1:0];
	assign in_range = (32'(bin_col) < sbha_pkg::Columns);

	assign recip_prod = 32'(prod_s2) * 32'(sbha_pkg::RecipMul);

	assign kept    = v_s3 && (h_s3 >= sbha_pkg::MinKept) && (cnt_q < sbha_pkg::MaxBins);
	assign sum_nxt = sum_q + (kept ? sbha_pkg::SumW'(h_s3) : '0);
	assign cnt_nxt = cnt_q + sbha_pkg::CntW'(kept);

	// hold the whole front end while a last bin waits for queue space
	assign stall     = v_s3 && last_s3 && queue_full;
	assign bin_ready = !stall;
	assign job_push  = v_s3 && last_s3 && !queue_full;
	assign job.col   = col_s3;
	assign job.sum   = sum_nxt;
	assign job.cnt   = cnt_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (!stall) begin
			v_s1 <= bin_valid && in_range;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				if (last_s3) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_nxt;
					cnt_q <= cnt_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			pct_s1  <= pct;
			col_s1  <= bin_col;
			last_s1 <= bin_last;
			prod_s2 <= sbha_pkg::ProdW'(sbha_pkg::Rows) * sbha_pkg::ProdW'(pct_s1);
			col_s2  <= col_s1;
			last_s2 <= last_s1;
			h_s3    <= recip_prod[sbha_pkg::RecipShift +: sbha_pkg::HeightW];
			col_s3  <= col_s2;
			last_s3 <= last_s2;
		end
	end

	a_clear_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |=> (sum_q == '0) && (cnt_q == '0))
		else $error("running sum not cleared after column job");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= sbha_pkg::MaxBins)
		else $error("running count above bin limit");

endmodule

@@ src/sbha_queue.sv @@
// Short job queue between the front end and the back end.
// Register-based FIFO of column jobs. Depends on sbha_pkg.
module sbha_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sbha_pkg::col_job_t push_job,
	output logic               full,
	input  logic               pop,
	output logic               job_valid,
	output sbha_pkg::col_job_t job
);

	sbha_pkg::col_job_t            mem_q [sbha_pkg::QueueDepth];
	logic [sbha_pkg::PtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [sbha_pkg::PtrW:0]       fill_q;

	assign full      = (32'(fill_q) == sbha_pkg::QueueDepth);
	assign job_valid = (fill_q != '0);
	assign job       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			fill_q <= fill_q + (sbha_pkg::PtrW+1)'(push) - (sbha_pkg::PtrW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full job queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> job_valid)
		else $error("pop from empty job queue");

endmodule

@@ src/sbha_back.sv @@
// Back end: divides each column sum by its count, smooths against the stored
// height and drives the result register. Depends on sbha_pkg.
module sbha_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	input  sbha_pkg::col_job_t           job,
	output logic                         pop,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [sbha_pkg::ColW-1:0]    res_col,
	output logic [sbha_pkg::HeightW-1:0] res_height
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [sbha_pkg::StepW-1:0]    step_q;
	logic [sbha_pkg::HeightW-1:0]  heights_q [2**sbha_pkg::ColW];
	logic [sbha_pkg::ColW-1:0]     col_q;
	logic [sbha_pkg::HeightW-1:0]  prev_q;
	logic [sbha_pkg::SumW-1:0]     quo_q;
	logic [sbha_pkg::CntW-1:0]     rem_q;
	logic [sbha_pkg::CntW-1:0]     div_q;
	logic [sbha_pkg::CntW:0]       shifted;
	logic                          fits;
	logic [sbha_pkg::HeightW:0]    blend;
	logic                          res_free;
	logic                          finish;

	assign pop      = (state_q == ST_IDLE) && job_valid;
	assign shifted  = {rem_q, quo_q[sbha_pkg::SumW-1]};
	assign fits     = (shifted >= {1'b0, div_q});
	assign blend    = {1'b0, quo_q[sbha_pkg::HeightW-1:0]} + {1'b0, prev_q};
	assign res_free = !res_valid || res_ready;
	assign finish   = (state_q == ST_DONE) && res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			res_valid  <= 1'b0;
			res_col    <= '0;
			res_height <= '0;
			for (int i = 0; i < 2**sbha_pkg::ColW; i++)
				heights_q[i] <= '0;
		end else begin
			if (res_ready && !finish)
				res_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (job_valid)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (32'(step_q) == sbha_pkg::SumW - 1)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					// finish as soon as the result register can take a new value
					if (res_free) begin
						heights_q[col_q] <= blend[sbha_pkg::HeightW:1];
						res_col          <= col_q;
						res_height       <= blend[sbha_pkg::HeightW:1];
						res_valid        <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			col_q  <= job.col;
			prev_q <= heights_q[job.col];
			quo_q  <= job.sum;
			rem_q  <= '0;
			div_q  <= (job.cnt == '0) ? sbha_pkg::CntW'(1) : job.cnt;
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[sbha_pkg::SumW-2:0], fits};
			rem_q <= fits ? sbha_pkg::CntW'(shifted - {1'b0, div_q})
				: shifted[sbha_pkg::CntW-1:0];
		end
	end

	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (32'(res_height) <= sbha_pkg::Rows))
		else $error("bar height above row count");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (32'(step_q) < sbha_pkg::SumW))
		else $error("divider ran past its last step");

endmodule

@@ src/spectrum_bar_height_averager.sv @@
// Top level of the spectrum bar height averager.
// Ties front end, job queue and back end together; depends on sbha_pkg.
//
// Channel | Dir | Handshake          | Content
// s_      | in  | s_tvalid/s_tready  | s_tdata bin magnitude + column, s_tlast end of column
// m_      | out | m_tvalid/m_tready  | m_tdata column + new bar height
//
// Bins are taken one per clock while s_tready is high. A column's last bin passes stages
// s1 to s3, the job queue and the back end's divide and done states before m_tvalid rises.
// The back end takes one column at a time; its divider makes one quotient bit per cycle.
// The four-entry job queue absorbs bursts of short columns; when it is full, a last bin
// holds s_tready low until the back end frees an entry.
// Reset clears the stored bar heights, the running sum and count and all valid flags.
module spectrum_bar_height_averager (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [15:0] bin_magnitude, [19:16] column_index, [23:20] zero
	input  logic        s_tlast,  // last_in_column
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [3:0] out_column, [11:4] bar_height, [15:12] zero
);

	sbha_pkg::col_job_t              push_job;
	sbha_pkg::col_job_t              head_job;
	logic                            job_push;
	logic                            queue_full;
	logic                            job_pop;
	logic                            job_valid;
	logic [sbha_pkg::ColW-1:0]       res_col;
	logic [sbha_pkg::HeightW-1:0]    res_height;

	sbha_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bin_valid  (s_tvalid),
		.bin_ready  (s_tready),
		.bin_mag    (s_tdata[15:0]),
		.bin_col    (s_tdata[19:16]),
		.bin_last   (s_tlast),
		.queue_full (queue_full),
		.job_push   (job_push),
		.job        (push_job)
	);

	sbha_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (job_pop),
		.job_valid (job_valid),
		.job       (head_job)
	);

	sbha_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (head_job),
		.pop        (job_pop),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_col    (res_col),
		.res_height (res_height)
	);

	assign m_tdata = {4'd0, res_height, res_col};

endmodule
